// ===== design/rvr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Rodrigues vector rotation block.
`timescale 1ns / 1ps

package rvr_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 31;

  localparam int ST_IN     = 0;
  localparam int ST_NORM   = 1;
  localparam int ST_SQR    = 2;
  localparam int ST_SUM    = 3;
  localparam int ST_SQRT0  = 4;
  localparam int ST_DIVSET = ST_SQRT0 + SQRT_STAGES;
  localparam int ST_DIV0   = ST_DIVSET + 1;
  localparam int ST_UNIT   = ST_DIV0 + DIV_STAGES;
  localparam int ST_PROD   = ST_UNIT + 1;
  localparam int ST_RND    = ST_PROD + 1;
  localparam int ST_MUL2   = ST_RND + 1;
  localparam int ST_RND2   = ST_MUL2 + 1;
  localparam int ST_MUL3   = ST_RND2 + 1;
  localparam int ST_OUT    = ST_MUL3 + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

  localparam int ADDR_W = 5;
  localparam logic [ADDR_W-1:0] ADDR_SHARED_ANGLE = 5'd4;

  typedef enum logic [2:0] {
    REG_ANGLE_SHARED = 3'd0,
    REG_SHARED_ANGLE = 3'd1,
    REG_AXIS_SHARED  = 3'd2,
    REG_SHARED_AX_X  = 3'd3,
    REG_SHARED_AX_Y  = 3'd4,
    REG_SHARED_AX_Z  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_AXIS = 2'd1,
    STATUS_SAT       = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0]       angle;
    logic [2:0][31:0]  axis;
    logic [2:0][31:0]  vec;
    logic              last;
    logic [2:0][31:0]  mag;
    logic [2:0]        neg_a;
    logic              zero;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [35:0] cz;
    logic              cneg;
    logic [2:0][62:0]  sq;
    logic [63:0]       rad;
    logic [63:0]       res;
    logic [32:0]       nrm;
    logic signed [35:0] cosv;
    logic signed [35:0] sinv;
    logic [2:0][32:0]  rem;
    logic [2:0][30:0]  quo;
    logic [2:0][30:0]  low;
    logic [2:0][31:0]  u;
    logic [2:0][63:0]  uv;
    logic [2:0][63:0]  cr1;
    logic [2:0][63:0]  cr2;
    logic [2:0][63:0]  cv;
    logic signed [35:0] p;
    logic [2:0][35:0]  q;
    logic [2:0][35:0]  rcv;
    logic [63:0]       omcp;
    logic [2:0][63:0]  sq2;
    logic signed [35:0] t;
    logic [2:0][35:0]  rsq;
    logic [2:0][63:0]  tu;
    logic [2:0][31:0]  rot;
    status_e           status;
  } pipe_t;

  function automatic logic signed [35:0] atan_q30(input int idx);
    logic signed [35:0] r;
    unique case (idx)
      0:  r = 36'sd843314857;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043837;
      3:  r = 36'sd133525159;
      4:  r = 36'sd67021687;
      5:  r = 36'sd33543516;
      6:  r = 36'sd16775851;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194283;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      24: r = 36'sd64;
      25: r = 36'sd32;
      26: r = 36'sd16;
      27: r = 36'sd8;
      28: r = 36'sd4;
      29: r = 36'sd2;
      default: r = 36'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [35:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v + 64'sd536870912) >>> 30;
    return w[35:0];
  endfunction

  function automatic logic signed [63:0] mul_s(input logic signed [35:0] a,
                                               input logic signed [35:0] b);
    logic signed [71:0] pr;
    pr = a * b;
    return pr[63:0];
  endfunction

endpackage

// ===== design/rodrigues_vector_rotation_top.sv =====
// Top level of the Rodrigues vector rotation pipeline with its register port.
`timescale 1ns / 1ps

// Each request carries an angle, an axis and a vector; the block returns the
// vector rotated about the normalized axis, with a status code and the batch
// marker copied through. Input and output use valid and stall: a request is
// taken on a clock edge where valid is high and stall is low.
// The pipeline has 75 register stages. One request is taken every cycle
// unless every stage is full behind a stalled output; the rate is set by
// the one-step-per-stage square root, divider and CORDIC sections.
// Each stage moves whenever it is empty or the stage after it moves, so a
// stalled output freezes only the occupied stages behind it and empty slots
// keep filling. Nothing is lost or repeated under stall.
// The APB port holds the shared angle and axis registers; write them only
// while no request is in flight. Reset empties the pipeline and restores the
// registers, with the shared axis pointing along z.
module rodrigues_vector_rotation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] angle_i,
  input  logic [31:0] axis_x_i,
  input  logic [31:0] axis_y_i,
  input  logic [31:0] axis_z_i,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic        last_in_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] rot_x_o,
  output logic [31:0] rot_y_o,
  output logic [31:0] rot_z_o,
  output logic [1:0]  status_o,
  output logic        last_out_o
);

  localparam int N = rvr_pkg::NUM_STAGES;
  localparam int DIV_STAGES_M1 = rvr_pkg::DIV_STAGES - 1;

  logic        angle_shared_q;
  logic [31:0] shared_angle_q;
  logic        axis_shared_q;
  logic [31:0] shared_ax_x_q;
  logic [31:0] shared_ax_y_q;
  logic [31:0] shared_ax_z_q;
  logic        wr_en;
  rvr_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = rvr_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_shared_q <= 1'b0;
      shared_angle_q <= '0;
      axis_shared_q  <= 1'b0;
      shared_ax_x_q  <= '0;
      shared_ax_y_q  <= '0;
      shared_ax_z_q  <= 32'h7FFF_FFFF;
    end else if (wr_en) begin
      unique case (reg_idx)
        rvr_pkg::REG_ANGLE_SHARED: angle_shared_q <= pwdata[0];
        rvr_pkg::REG_SHARED_ANGLE: shared_angle_q <= pwdata;
        rvr_pkg::REG_AXIS_SHARED:  axis_shared_q  <= pwdata[0];
        rvr_pkg::REG_SHARED_AX_X:  shared_ax_x_q  <= pwdata;
        rvr_pkg::REG_SHARED_AX_Y:  shared_ax_y_q  <= pwdata;
        rvr_pkg::REG_SHARED_AX_Z:  shared_ax_z_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rvr_pkg::REG_ANGLE_SHARED: prdata = {31'd0, angle_shared_q};
      rvr_pkg::REG_SHARED_ANGLE: prdata = shared_angle_q;
      rvr_pkg::REG_AXIS_SHARED:  prdata = {31'd0, axis_shared_q};
      rvr_pkg::REG_SHARED_AX_X:  prdata = shared_ax_x_q;
      rvr_pkg::REG_SHARED_AX_Y:  prdata = shared_ax_y_q;
      rvr_pkg::REG_SHARED_AX_Z:  prdata = shared_ax_z_q;
      default:                   prdata = '0;
    endcase
  end

  rvr_pkg::pipe_t pipe_d [N];
  rvr_pkg::pipe_t pipe_q [N];
  logic [N-1:0]   vld_q;
  logic [N-1:0]   en;

  always_comb begin
    pipe_d[0]       = pipe_q[0];
    pipe_d[0].angle = angle_shared_q ? shared_angle_q : angle_i;
    pipe_d[0].axis  = axis_shared_q ? {shared_ax_z_q, shared_ax_y_q, shared_ax_x_q}
                                    : {axis_z_i, axis_y_i, axis_x_i};
    pipe_d[0].vec   = {vec_z_i, vec_y_i, vec_x_i};
    pipe_d[0].last  = last_in_i;
  end

  for (genvar k = 1; k < N; k++) begin : g_stage
    if (k == rvr_pkg::ST_NORM) begin : g_norm
      always_comb begin
        rvr_pkg::pipe_t     a;
        logic [31:0]        m;
        logic [4:0]         h;
        logic [4:0]         sh;
        logic signed [35:0] z;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          a.neg_a[j] = a.axis[j][31];
          a.mag[j]   = a.axis[j][31] ? 32'(-a.axis[j]) : a.axis[j];
        end
        m = a.mag[0];
        if (a.mag[1] > m) m = a.mag[1];
        if (a.mag[2] > m) m = a.mag[2];
        a.zero = (m == 32'd0);
        h = '0;
        for (int b = 0; b < 32; b++) begin
          if (m[b]) h = 5'(b);
        end
        sh = (h >= 5'd30) ? 5'd0 : 5'(5'd30 - h);
        for (int j = 0; j < 3; j++) begin
          a.mag[j] = a.mag[j] << sh;
        end
        z = $signed({{2{a.angle[31]}}, a.angle, 2'b00});
        if (z > rvr_pkg::PI_Q30) begin
          z = z - rvr_pkg::TWO_PI_Q30;
        end else if (z < -rvr_pkg::PI_Q30) begin
          z = z + rvr_pkg::TWO_PI_Q30;
        end
        a.cneg = 1'b0;
        if (z > rvr_pkg::HALF_PI_Q30) begin
          z      = z - rvr_pkg::PI_Q30;
          a.cneg = 1'b1;
        end else if (z < -rvr_pkg::HALF_PI_Q30) begin
          z      = z + rvr_pkg::PI_Q30;
          a.cneg = 1'b1;
        end
        a.cx = rvr_pkg::GAIN_Q30;
        a.cy = '0;
        a.cz = z;
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_SQR) begin : g_sqr
      always_comb begin
        rvr_pkg::pipe_t a;
        logic [63:0]    pr;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          pr       = a.mag[j] * a.mag[j];
          a.sq[j]  = pr[62:0];
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_SUM) begin : g_sum
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        a.rad = 64'(a.sq[0]) + 64'(a.sq[1]) + 64'(a.sq[2]);
        a.res = '0;
        pipe_d[k] = a;
      end
    end else if (k < rvr_pkg::ST_DIVSET) begin : g_sqrt
      localparam int I = k - rvr_pkg::ST_SQRT0;
      always_comb begin
        rvr_pkg::pipe_t     a;
        logic [63:0]        bitv;
        logic [63:0]        trial;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        a     = pipe_q[k-1];
        bitv  = 64'd1 << (62 - 2 * I);
        trial = a.res + bitv;
        if (a.rad >= trial) begin
          a.rad = a.rad - trial;
          a.res = (a.res >> 1) + bitv;
        end else begin
          a.res = a.res >> 1;
        end
        if (I < rvr_pkg::CORDIC_STAGES) begin
          dx = a.cy >>> I;
          dy = a.cx >>> I;
          if (a.cz >= 0) begin
            a.cx = a.cx - dx;
            a.cy = a.cy + dy;
            a.cz = a.cz - rvr_pkg::atan_q30(I);
          end else begin
            a.cx = a.cx + dx;
            a.cy = a.cy - dy;
            a.cz = a.cz + rvr_pkg::atan_q30(I);
          end
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_DIVSET) begin : g_divset
      always_comb begin
        rvr_pkg::pipe_t a;
        logic [61:0]    dvd;
        a      = pipe_q[k-1];
        a.nrm  = a.res[32:0];
        a.cosv = a.cneg ? -a.cx : a.cx;
        a.sinv = a.cneg ? -a.cy : a.cy;
        for (int j = 0; j < 3; j++) begin
          dvd      = {a.mag[j], 30'd0} + 62'(a.nrm >> 1);
          a.rem[j] = {2'b00, dvd[61:31]};
          a.low[j] = dvd[30:0];
          a.quo[j] = '0;
        end
        pipe_d[k] = a;
      end
    end else if (k < rvr_pkg::ST_UNIT) begin : g_div
      localparam int B = k - rvr_pkg::ST_DIV0;
      always_comb begin
        rvr_pkg::pipe_t a;
        logic [32:0]    tr;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          tr = {a.rem[j][31:0], a.low[j][DIV_STAGES_M1 - B]};
          if (tr >= a.nrm) begin
            a.rem[j] = tr - a.nrm;
            a.quo[j] = {a.quo[j][29:0], 1'b1};
          end else begin
            a.rem[j] = tr;
            a.quo[j] = {a.quo[j][29:0], 1'b0};
          end
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_UNIT) begin : g_unit
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          a.u[j] = a.neg_a[j] ? -{1'b0, a.quo[j]} : {1'b0, a.quo[j]};
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_PROD) begin : g_prod
      always_comb begin
        rvr_pkg::pipe_t a;
        int             j1;
        int             j2;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          j1 = (j + 1) % 3;
          j2 = (j + 2) % 3;
          a.uv[j]  = rvr_pkg::mul_s(36'($signed(a.u[j])), 36'($signed(a.vec[j])));
          a.cr1[j] = rvr_pkg::mul_s(36'($signed(a.u[j1])), 36'($signed(a.vec[j2])));
          a.cr2[j] = rvr_pkg::mul_s(36'($signed(a.u[j2])), 36'($signed(a.vec[j1])));
          a.cv[j]  = rvr_pkg::mul_s(a.cosv, 36'($signed(a.vec[j])));
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_RND) begin : g_rnd
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        a.p = rvr_pkg::rnd30($signed(a.uv[0]) + $signed(a.uv[1]) + $signed(a.uv[2]));
        for (int j = 0; j < 3; j++) begin
          a.q[j]   = rvr_pkg::rnd30($signed(a.cr1[j]) - $signed(a.cr2[j]));
          a.rcv[j] = rvr_pkg::rnd30($signed(a.cv[j]));
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_MUL2) begin : g_mul2
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        a.omcp = rvr_pkg::mul_s(rvr_pkg::ONE_Q30 - a.cosv, a.p);
        for (int j = 0; j < 3; j++) begin
          a.sq2[j] = rvr_pkg::mul_s(a.sinv, $signed(a.q[j]));
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_RND2) begin : g_rnd2
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        a.t = rvr_pkg::rnd30($signed(a.omcp));
        for (int j = 0; j < 3; j++) begin
          a.rsq[j] = rvr_pkg::rnd30($signed(a.sq2[j]));
        end
        pipe_d[k] = a;
      end
    end else if (k == rvr_pkg::ST_MUL3) begin : g_mul3
      always_comb begin
        rvr_pkg::pipe_t a;
        a = pipe_q[k-1];
        for (int j = 0; j < 3; j++) begin
          a.tu[j] = rvr_pkg::mul_s(a.t, 36'($signed(a.u[j])));
        end
        pipe_d[k] = a;
      end
    end else begin : g_out
      always_comb begin
        rvr_pkg::pipe_t     a;
        logic signed [37:0] s;
        a = pipe_q[k-1];
        a.status = rvr_pkg::STATUS_OK;
        for (int j = 0; j < 3; j++) begin
          s = 38'($signed(a.rcv[j])) + 38'($signed(a.rsq[j]))
            + 38'(rvr_pkg::rnd30($signed(a.tu[j])));
          if (s > 38'sd2147483647) begin
            a.rot[j] = 32'h7FFF_FFFF;
            a.status = rvr_pkg::STATUS_SAT;
          end else if (s < -38'sd2147483648) begin
            a.rot[j] = 32'h8000_0000;
            a.status = rvr_pkg::STATUS_SAT;
          end else begin
            a.rot[j] = s[31:0];
          end
        end
        if (a.zero) begin
          a.rot    = a.vec;
          a.status = rvr_pkg::STATUS_ZERO_AXIS;
        end
        pipe_d[k] = a;
      end
    end
  end

  always_comb begin
    en[N-1] = !vld_q[N-1] || !stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  assign stall_o    = !en[0];
  assign valid_o    = vld_q[N-1];
  assign rot_x_o    = pipe_q[N-1].rot[0];
  assign rot_y_o    = pipe_q[N-1].rot[1];
  assign rot_z_o    = pipe_q[N-1].rot[2];
  assign status_o   = pipe_q[N-1].status;
  assign last_out_o = pipe_q[N-1].last;

endmodule

// ===== design/rvr_checker.sv =====
// Port-level checks for the Rodrigues vector rotation top level, bound to it.
`timescale 1ns / 1ps

module rvr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] rot_x_o,
  input logic [31:0] rot_y_o,
  input logic [31:0] rot_z_o,
  input logic [1:0]  status_o,
  input logic        last_out_o
);

  // The input only stalls when every stage is full back to a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a stalled output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o
      && $stable({rot_x_o, rot_y_o, rot_z_o, status_o, last_out_o}))
    else $error("stalled result changed");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == rvr_pkg::ADDR_SHARED_ANGLE
      |=> paddr != rvr_pkg::ADDR_SHARED_ANGLE || prdata == $past(pwdata))
    else $error("shared angle readback mismatch");

endmodule

bind rodrigues_vector_rotation_top rvr_checker u_rvr_checker (.*);

// ===== tb/rodrigues_vector_rotation_top_test.sv =====
// Self-checking testbench for the Rodrigues vector rotation block.
`timescale 1ns / 1ps

module rodrigues_vector_rotation_top_test;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] axis [3];
    logic signed [31:0] vec [3];
    logic               last;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] rot [3];
    rvr_pkg::status_e   status;
    logic               last;
  } rot_res_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0, stall_o;
  logic [31:0] angle_i = '0, axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic last_in_i = 1'b0;
  logic valid_o, stall_i = 1'b0;
  logic [31:0] rot_x_o, rot_y_o, rot_z_o;
  logic [1:0] status_o;
  logic last_out_o;

  rot_req_t pending_reqs [$];
  rot_res_t expected_rots [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit quiet = 1'b0;

  logic               cfg_angle_shared = 1'b0;
  logic signed [31:0] cfg_shared_angle = '0;
  logic               cfg_axis_shared = 1'b0;
  logic signed [31:0] cfg_shared_axis [3] = '{32'sd0, 32'sd0, 32'h7FFFFFFF};

  longint atan_tab [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 1};

  rodrigues_vector_rotation_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint round_q30(longint x);
    return (x + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void cordic_sincos(input logic signed [31:0] ang,
                                        output longint cosv, output longint sinv);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 4;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd3373259426) z = z - 64'sd6746518852;
    else if (z < -64'sd3373259426) z = z + 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z = z - 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z = z + 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < rvr_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    cosv = flip ? -x : x;
    sinv = flip ? -y : y;
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t req);
    rot_res_t res;
    longint a [3], v [3], u [3], r [3];
    longint c, s, p, t, q;
    longint unsigned mag [3], m, sum, nrm;
    int k;
    res.status = rvr_pkg::STATUS_OK;
    res.last = req.last;
    for (int j = 0; j < 3; j++) begin
      a[j] = cfg_axis_shared ? longint'(cfg_shared_axis[j]) : longint'(req.axis[j]);
      v[j] = longint'(req.vec[j]);
      mag[j] = a[j] < 0 ? -a[j] : a[j];
    end
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    if (m == 0) begin
      for (int j = 0; j < 3; j++) res.rot[j] = req.vec[j];
      res.status = rvr_pkg::STATUS_ZERO_AXIS;
      return res;
    end
    k = 0;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      k++;
    end
    sum = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = mag[j] << k;
      sum = sum + mag[j] * mag[j];
    end
    nrm = int_sqrt(sum);
    for (int j = 0; j < 3; j++) begin
      q = longint'(((mag[j] << 30) + (nrm >> 1)) / nrm);
      u[j] = a[j] < 0 ? -q : q;
    end
    cordic_sincos(cfg_angle_shared ? cfg_shared_angle : req.angle, c, s);
    p = round_q30(u[0] * v[0] + u[1] * v[1] + u[2] * v[2]);
    t = round_q30((64'sd1073741824 - c) * p);
    for (int j = 0; j < 3; j++) begin
      q = round_q30(u[(j + 1) % 3] * v[(j + 2) % 3] - u[(j + 2) % 3] * v[(j + 1) % 3]);
      r[j] = round_q30(c * v[j]) + round_q30(s * q) + round_q30(t * u[j]);
      if (r[j] > 64'sd2147483647) begin
        r[j] = 64'sd2147483647;
        res.status = rvr_pkg::STATUS_SAT;
      end else if (r[j] < -64'sd2147483648) begin
        r[j] = -64'sd2147483648;
        res.status = rvr_pkg::STATUS_SAT;
      end
      res.rot[j] = r[j][31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $time, field, got, want);
    mismatches++;
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      expected_rots.push_back(rotate_vector(pending_reqs[0]));
      void'(pending_reqs.pop_front());
      if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
    end
    if (!(valid_i && stall_o)) begin
      if (send_gap > 0) begin
        send_gap--;
        valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && rst_ni) begin
        valid_i <= 1'b1;
        angle_i <= pending_reqs[0].angle;
        axis_x_i <= pending_reqs[0].axis[0];
        axis_y_i <= pending_reqs[0].axis[1];
        axis_z_i <= pending_reqs[0].axis[2];
        vec_x_i <= pending_reqs[0].vec[0];
        vec_y_i <= pending_reqs[0].vec[1];
        vec_z_i <= pending_reqs[0].vec[2];
        last_in_i <= pending_reqs[0].last;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin
    rot_res_t want;
    if (valid_o && !stall_i) begin
      if (expected_rots.size() == 0) begin
        report_mismatch("valid_o", 32'd1, 32'd0);
      end else begin
        want = expected_rots.pop_front();
        if (rot_x_o !== want.rot[0]) report_mismatch("rot_x", rot_x_o, want.rot[0]);
        if (rot_y_o !== want.rot[1]) report_mismatch("rot_y", rot_y_o, want.rot[1]);
        if (rot_z_o !== want.rot[2]) report_mismatch("rot_z", rot_z_o, want.rot[2]);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (last_out_o !== want.last) report_mismatch("last", last_out_o, want.last);
      end
    end
    if (quiet) begin
      stall_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 2);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic apb_write(rvr_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rvr_pkg::REG_ANGLE_SHARED: cfg_angle_shared = val[0];
      rvr_pkg::REG_SHARED_ANGLE: cfg_shared_angle = val;
      rvr_pkg::REG_AXIS_SHARED:  cfg_axis_shared = val[0];
      rvr_pkg::REG_SHARED_AX_X:  cfg_shared_axis[0] = val;
      rvr_pkg::REG_SHARED_AX_Y:  cfg_shared_axis[1] = val;
      rvr_pkg::REG_SHARED_AX_Z:  cfg_shared_axis[2] = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rots.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(bit wide);
    if (wide || $urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
  endfunction

  task automatic queue_req(logic [31:0] ang, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] az, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, logic lst);
    rot_req_t req;
    req.angle = ang;
    req.axis = '{ax, ay, az};
    req.vec = '{vx, vy, vz};
    req.last = lst;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_random(int count);
    logic [31:0] ax, ay, az;
    bit wide;
    for (int n = 0; n < count; n++) begin
      wide = $urandom_range(0, 3) == 0;
      ax = rand_coord(wide);
      ay = rand_coord(wide);
      az = rand_coord(wide);
      case ($urandom_range(0, 9))
        0: begin ax = '0; ay = '0; az = '0; end
        1: ay = '0;
        2: begin ax = $urandom_range(0, 3); ay = '0; end
        default: ;
      endcase
      queue_req($urandom(), ax, ay, az, rand_coord(wide), rand_coord(wide),
                rand_coord(wide), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_req(32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h20000, 32'h30000, 1'b0);
    queue_req(32'h1921FB54, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0, 1'b1);
    queue_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    queue_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    queue_req(32'h3243F6A9, 32'h1, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h0, 1'b0);
    queue_req(32'hCDBC0957, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h0,
              32'h7FFFFFFF, 1'b0);
    queue_req(32'h1921FB54, 32'h10000, 32'h10000, 32'h0, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 1'b0);
    queue_req(32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b1);
    queue_req(32'h6487ED51, 32'h0, 32'h80000000, 32'h1, 32'h12345, 32'hFFFF0000,
              32'h0, 1'b0);
    queue_req(32'hE6DE04AB, 32'h7FFFFFFF, 32'h1, 32'h80000000, 32'h5555AAAA,
              32'hAAAA5555, 32'hFFFFFFFF, 1'b1);
    queue_random(80);
    wait_drained();

    apb_write(rvr_pkg::REG_ANGLE_SHARED, 32'h1);
    apb_write(rvr_pkg::REG_SHARED_ANGLE, 32'h7FFFFFFF);
    queue_random(70);
    wait_drained();

    apb_write(rvr_pkg::REG_SHARED_ANGLE, 32'h80000000);
    apb_write(rvr_pkg::REG_AXIS_SHARED, 32'h1);
    apb_write(rvr_pkg::REG_SHARED_AX_X, 32'h80000000);
    apb_write(rvr_pkg::REG_SHARED_AX_Y, 32'h7FFFFFFF);
    apb_write(rvr_pkg::REG_SHARED_AX_Z, 32'h1);
    queue_random(70);
    wait_drained();

    apb_write(rvr_pkg::REG_SHARED_AX_X, 32'h0);
    apb_write(rvr_pkg::REG_SHARED_AX_Y, 32'h0);
    apb_write(rvr_pkg::REG_SHARED_AX_Z, 32'h0);
    apb_write(rvr_pkg::REG_ANGLE_SHARED, 32'h0);
    queue_random(40);
    wait_drained();

    apb_write(rvr_pkg::REG_SHARED_AX_X, $urandom());
    apb_write(rvr_pkg::REG_SHARED_AX_Y, $urandom());
    apb_write(rvr_pkg::REG_SHARED_AX_Z, $urandom());
    apb_write(rvr_pkg::REG_SHARED_ANGLE, $urandom());
    apb_write(rvr_pkg::REG_ANGLE_SHARED, 32'h1);
    queue_random(70);
    wait_drained();

    apb_write(rvr_pkg::REG_ANGLE_SHARED, 32'h0);
    apb_write(rvr_pkg::REG_AXIS_SHARED, 32'h0);
    queue_random(110);
    while (pending_reqs.size() > 30) @(posedge clk_i);
    quiet = 1'b1;
    wait_drained();

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rvr_pkg.sv
design/rodrigues_vector_rotation_top.sv
design/rvr_checker.sv
tb/rodrigues_vector_rotation_top_test.sv
